// ===== src/hmf_pkg.sv =====
`timescale 1ns / 1ps
// hmf_pkg: shared constants, types and item layout for the histogram mode finder.
// No dependencies; imported by hmf_front, hmf_back and histogram_mode_finder.

package hmf_pkg;

    localparam int NUM_BINS      = 511;
    localparam int COUNT_WIDTH   = 16;
    localparam int SAMPLE_W      = 9;
    localparam int SAMPLE_OFFSET = 255;
    localparam int MODE_COUNT_W  = 16;

    localparam int BIN_W         = $clog2(NUM_BINS);
    localparam int ROW_COUNT     = (NUM_BINS + 1) / 2;
    localparam int ROW_W         = $clog2(ROW_COUNT);
    localparam int ROW_DATA_W    = 2 * COUNT_WIDTH;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam int IN_TDATA_W    = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W  = SAMPLE_W + MODE_COUNT_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef struct packed {
        logic [ROW_W-1:0]           row;
        logic                       half;
        logic                       in_range;
        logic                       last;
        logic signed [SAMPLE_W-1:0] sample;
    } hmf_item_t;

    typedef struct packed {
        logic              valid;
        hmf_item_t         item;
        logic [QPTR_W:0]   count;
    } hmf_head_t;

endpackage

// ===== src/hmf_ram.sv =====
`timescale 1ns / 1ps
// hmf_ram: generic single-write, single-read RAM with registered read data.
// Read returns the old contents when read and write hit the same address.

module hmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/hmf_front.sv =====
`timescale 1ns / 1ps
// hmf_front: input beat acceptance, bin classification and the item queue.
// Depends on hmf_pkg; feeds hmf_back through an hmf_head_t.

module hmf_front
    import hmf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // [8:0] sample
    input  logic                  s_axis_tlast,   // last_sample
    output hmf_head_t             head,
    input  logic                  pop
);

    hmf_item_t                   item_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]             count_reg, count_next;

    logic signed [SAMPLE_W+1:0]  idx_wide;
    logic [BIN_W-1:0]            bin;
    hmf_item_t                   new_item;
    logic                        push;

    always_comb
    begin
        idx_wide = {{2{s_axis_tdata[SAMPLE_W-1]}}, s_axis_tdata[SAMPLE_W-1:0]}
                   + (SAMPLE_W+2)'(SAMPLE_OFFSET);
        bin      = idx_wide[BIN_W-1:0];
        new_item.row      = bin[BIN_W-1:1];
        new_item.half     = bin[0];
        new_item.in_range = !idx_wide[SAMPLE_W+1]
                            && (32'(idx_wide[SAMPLE_W:0]) < 32'(NUM_BINS));
        new_item.last     = s_axis_tlast;
        new_item.sample   = s_axis_tdata[SAMPLE_W-1:0];
    end

    assign s_axis_tready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = item_reg[rd_ptr_reg];
    assign head.count = count_reg;

endmodule

// ===== src/hmf_back.sv =====
`timescale 1ns / 1ps
// hmf_back: histogram read-modify-write with forwarding, running best, result register.
// Depends on hmf_pkg and hmf_ram; takes items from hmf_front.

module hmf_back
    import hmf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  hmf_head_t              head,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [8:0] mode_value, [24:9] mode_count
);

    logic                         pipe_valid_reg, pipe_valid_next;
    hmf_item_t                    pipe_item_reg;
    logic [ROW_COUNT-1:0]         row_vld_reg, row_vld_next;
    logic                         fwd_valid_reg, fwd_valid_next;
    logic [ROW_W-1:0]             fwd_row_reg;
    logic [ROW_DATA_W-1:0]        fwd_data_reg;
    logic [COUNT_WIDTH-1:0]       best_count_reg, best_count_next;
    logic signed [SAMPLE_W-1:0]   best_value_reg, best_value_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0]   out_value_reg;
    logic [MODE_COUNT_W-1:0]      out_count_reg;

    logic [ROW_DATA_W-1:0]        ram_rdata;
    logic [ROW_DATA_W-1:0]        row_data;
    logic [ROW_DATA_W-1:0]        new_row;
    logic [COUNT_WIDTH-1:0]       cur_count;
    logic [COUNT_WIDTH-1:0]       inc_count;
    logic [COUNT_WIDTH-1:0]       cand_count;
    logic signed [SAMPLE_W-1:0]   cand_value;
    logic                         better;
    logic                         out_free;
    logic                         pipe_fire;
    logic                         do_write;

    hmf_ram #(
        .WIDTH (ROW_DATA_W),
        .DEPTH (ROW_COUNT)
    ) u_hist_ram (
        .clk   (clk),
        .re    (pop),
        .raddr (head.item.row),
        .rdata (ram_rdata),
        .we    (do_write),
        .waddr (pipe_item_reg.row),
        .wdata (new_row)
    );

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign pipe_fire = pipe_valid_reg && (!pipe_item_reg.last || out_free);
    assign pop       = head.valid && (!pipe_valid_reg || pipe_fire);
    assign do_write  = pipe_fire && pipe_item_reg.in_range;

    always_comb
    begin
        if (fwd_valid_reg && (fwd_row_reg == pipe_item_reg.row))
        begin
            row_data = fwd_data_reg;
        end
        else if (row_vld_reg[pipe_item_reg.row])
        begin
            row_data = ram_rdata;
        end
        else
        begin
            row_data = '0;
        end

        cur_count = pipe_item_reg.half ? row_data[ROW_DATA_W-1:COUNT_WIDTH]
                                       : row_data[COUNT_WIDTH-1:0];
        inc_count = (cur_count != COUNT_MAX) ? cur_count + 1'b1 : cur_count;
        new_row   = pipe_item_reg.half ? {inc_count, row_data[COUNT_WIDTH-1:0]}
                                       : {row_data[ROW_DATA_W-1:COUNT_WIDTH], inc_count};

        better = pipe_item_reg.in_range
                 && ((inc_count > best_count_reg)
                     || ((inc_count == best_count_reg)
                         && ($signed(pipe_item_reg.sample) > $signed(best_value_reg))));
        cand_count = better ? inc_count : best_count_reg;
        cand_value = better ? pipe_item_reg.sample : best_value_reg;
    end

    always_comb
    begin
        pipe_valid_next = pop ? 1'b1 : (pipe_fire ? 1'b0 : pipe_valid_reg);
        row_vld_next    = row_vld_reg;
        fwd_valid_next  = fwd_valid_reg;
        best_count_next = best_count_reg;
        best_value_next = best_value_reg;
        out_valid_next  = m_axis_tready ? 1'b0 : out_valid_reg;

        if (pipe_fire)
        begin
            if (do_write)
            begin
                row_vld_next[pipe_item_reg.row] = 1'b1;
                fwd_valid_next                  = 1'b1;
            end
            best_count_next = cand_count;
            best_value_next = cand_value;
            if (pipe_item_reg.last)
            begin
                row_vld_next    = '0;
                fwd_valid_next  = 1'b0;
                best_count_next = '0;
                best_value_next = '0;
                out_valid_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
            row_vld_reg    <= '0;
            fwd_valid_reg  <= 1'b0;
            best_count_reg <= '0;
            best_value_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pipe_valid_reg <= pipe_valid_next;
            row_vld_reg    <= row_vld_next;
            fwd_valid_reg  <= fwd_valid_next;
            best_count_reg <= best_count_next;
            best_value_reg <= best_value_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pipe_item_reg <= head.item;
        end
        if (do_write)
        begin
            fwd_row_reg  <= pipe_item_reg.row;
            fwd_data_reg <= new_row;
        end
        if (pipe_fire && pipe_item_reg.last)
        begin
            out_value_reg <= cand_value;
            out_count_reg <= cand_count[MODE_COUNT_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W-OUT_FIELDS_W)'(0), out_count_reg, out_value_reg};

endmodule

// ===== src/histogram_mode_finder.sv =====
`timescale 1ns / 1ps
// histogram_mode_finder: top level of the run histogram mode finder.
// Depends on hmf_pkg, hmf_front, hmf_back (which holds hmf_ram).
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata[8:0] sample, tlast last_sample
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata[8:0] mode_value, [24:9] mode_count
//
// One beat per cycle sustained while no stalled result holds the back end;
// each sample is one read-modify-write of the 256-row histogram RAM (two bins
// per row) with one-deep write forwarding. A last beat passes the item queue
// and the pipeline register before its result is registered for output.
// Reset needs no clearing pass: per-row valid flags clear at reset and at
// the end of each run. A stalled result holds the back end only when the next
// last beat reaches it; the four-entry queue keeps the input side taking beats meanwhile.

module histogram_mode_finder
    import hmf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [8:0] sample
    input  logic                   s_axis_tlast,   // last_sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [8:0] mode_value, [24:9] mode_count
);

    hmf_head_t head;
    logic      pop;

    hmf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .head          (head),
        .pop           (pop)
    );

    hmf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head.count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[SAMPLE_W+MODE_COUNT_W-1:SAMPLE_W] == '0))
        |-> (m_axis_tdata[SAMPLE_W-1:0] == '0))
        else $error("zero count result with nonzero value");

endmodule

// ===== tb/histogram_mode_finder_test.sv =====
`timescale 1ns / 1ps
// histogram_mode_finder_test: drives sample runs into histogram_mode_finder and checks
// each mode beat against fixed values or a behavioral histogram model in this module.
// Depends on hmf_pkg and histogram_mode_finder.

module histogram_mode_finder_test;
    import hmf_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [MODE_COUNT_W-1:0]    count;
    } mode_result_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       lst;
        logic                       fixed_mode;
        mode_result_t               mode;
    } dir_row_t;

    localparam logic signed [SAMPLE_W-1:0] OUT_OF_RANGE = 9'sh100;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CALM_ITEMS   = 1450;

    localparam dir_row_t DIRECTED [0:24] = '{
        '{OUT_OF_RANGE, 1'b1, 1'b1, '{9'sd0, 16'd0}},
        '{9'sd255,      1'b1, 1'b1, '{9'sd255, 16'd1}},
        '{-9'sd255,     1'b1, 1'b1, '{-9'sd255, 16'd1}},
        '{9'sd0,        1'b1, 1'b1, '{9'sd0, 16'd1}},
        '{OUT_OF_RANGE, 1'b0, 1'b0, '{9'sd0, 16'd0}},
        '{OUT_OF_RANGE, 1'b1, 1'b1, '{9'sd0, 16'd0}},
        '{9'sd7,        1'b0, 1'b0, '{9'sd0, 16'd0}},
        '{OUT_OF_RANGE, 1'b0, 1'b0, '{9'sd0, 16'd0}},
        '{9'sd7,        1'b1, 1'b1, '{9'sd7, 16'd2}},
        '{-9'sd3,       1'b0, 1'b0, '{9'sd0, 16'd0}},
        '{9'sd5,        1'b0, 1'b0, '{9'sd0, 16'd0}},
        '{-9'sd3,       1'b0, 1'b0, '{9'sd0, 16'd0}},
        '{9'sd5,        1'b1, 1'b0, '{9'sd0, 16'd0}},
        '{9'sd255,      1'b0, 1'b0, '{9'sd0, 16'd0}},
        '{-9'sd255,     1'b0, 1'b0, '{9'sd0, 16'd0}},
        '{-9'sd255,     1'b0, 1'b0, '{9'sd0, 16'd0}},
        '{9'sd255,      1'b1, 1'b1, '{9'sd255, 16'd2}},
        '{-9'sd1,       1'b0, 1'b0, '{9'sd0, 16'd0}},
        '{-9'sd2,       1'b0, 1'b0, '{9'sd0, 16'd0}},
        '{-9'sd1,       1'b1, 1'b0, '{9'sd0, 16'd0}},
        '{9'sd1,        1'b0, 1'b0, '{9'sd0, 16'd0}},
        '{OUT_OF_RANGE, 1'b1, 1'b1, '{9'sd1, 16'd1}},
        '{9'sd128,      1'b0, 1'b0, '{9'sd0, 16'd0}},
        '{-9'sd128,     1'b0, 1'b0, '{9'sd0, 16'd0}},
        '{-9'sd128,     1'b1, 1'b1, '{-9'sd128, 16'd2}}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [8:0] sample
    logic                   s_axis_tlast;   // last_sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [8:0] mode_value, [24:9] mode_count

    logic [COUNT_WIDTH-1:0]     bin_cnt [NUM_BINS];
    bit                         bin_tag [NUM_BINS];
    bit                         run_tag;
    logic [COUNT_WIDTH-1:0]     best_cnt;
    logic signed [SAMPLE_W-1:0] best_val;

    mode_result_t pending_modes [$];
    int           fail_cnt;
    bit           src_idle;
    bit           sink_idle;

    histogram_mode_finder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("histogram_mode_finder test failed");
        $finish;
    end

    function automatic bit tally_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst,
                                        output mode_result_t res);
        int                     idx;
        logic [COUNT_WIDTH-1:0] c;
        idx = int'(smp) + SAMPLE_OFFSET;
        res = '0;
        if (idx >= 0 && idx < NUM_BINS)
        begin
            c = (bin_tag[idx] == run_tag) ? bin_cnt[idx] : '0;
            if (c != COUNT_MAX)
                c = c + 1'b1;
            bin_cnt[idx] = c;
            bin_tag[idx] = run_tag;
            if (c > best_cnt || (c == best_cnt && smp > best_val))
            begin
                best_cnt = c;
                best_val = smp;
            end
        end
        if (!lst)
            return 1'b0;
        res.value = best_val;
        res.count = best_cnt[MODE_COUNT_W-1:0];
        // flash clear: every bin tag now mismatches the new run tag
        run_tag = ~run_tag;
        for (int i = 0; i < NUM_BINS; i++)
            bin_tag[i] = ~run_tag;
        best_cnt = '0;
        best_val = '0;
        return 1'b1;
    endfunction

    task automatic send_beat(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
        if (src_idle && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_TDATA_W'($urandom);
            s_axis_tlast  <= 1'($urandom);
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - SAMPLE_W){1'b0}}, smp};
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic play_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
        mode_result_t res;
        send_beat(smp, lst);
        if (tally_sample(smp, lst, res))
            pending_modes.push_back(res);
    endtask

    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (sink_idle && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        mode_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_modes.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected mode beat: value %0d count %0d",
                             $signed(m_axis_tdata[8:0]), m_axis_tdata[24:9]);
            end
            else
            begin
                want = pending_modes.pop_front();
                if (m_axis_tdata[8:0] !== want.value || m_axis_tdata[24:9] !== want.count)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("mode mismatch: expected value %0d count %0d, got %0d %0d",
                                 want.value, want.count,
                                 $signed(m_axis_tdata[8:0]), m_axis_tdata[24:9]);
                end
            end
        end
    end

    initial
    begin
        int                         n_items;
        int                         run_len;
        bit                         narrow;
        logic signed [SAMPLE_W-1:0] pool [4];
        logic signed [SAMPLE_W-1:0] smp;
        mode_result_t               res;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        fail_cnt  = 0;
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        for (int i = 0; i < NUM_BINS; i++)
        begin
            bin_cnt[i] = '0;
            bin_tag[i] = 1'b0;
        end
        run_tag  = 1'b1;
        best_cnt = '0;
        best_val = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_beat(DIRECTED[i].smp, DIRECTED[i].lst);
            if (tally_sample(DIRECTED[i].smp, DIRECTED[i].lst, res))
                pending_modes.push_back(DIRECTED[i].fixed_mode ? DIRECTED[i].mode : res);
        end

        n_items = 0;
        while (n_items < RANDOM_ITEMS)
        begin
            run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 600)
                                                   : $urandom_range(1, 24);
            narrow = $urandom_range(0, 2) != 0;
            foreach (pool[j])
                pool[j] = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 9'sd255 : -9'sd255)
                                                      : SAMPLE_W'($urandom_range(0, 510) - 255);
            for (int k = 0; k < run_len; k++)
            begin
                if (n_items > CALM_ITEMS)
                begin
                    src_idle  = 1'b0;
                    sink_idle = 1'b0;
                end
                if ($urandom_range(0, 19) == 0)
                    smp = SAMPLE_W'($urandom);
                else if (narrow)
                    smp = pool[$urandom_range(0, 3)];
                else
                    smp = SAMPLE_W'($urandom_range(0, 510) - 255);
                play_sample(smp, k == run_len - 1);
                n_items++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_modes.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (m_axis_tvalid)
        begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("extra mode beat pending at end of run");
        end
        if (fail_cnt == 0)
            $display("histogram_mode_finder test passed");
        else
            $display("histogram_mode_finder test failed");
        $finish;
    end

endmodule
